>>> design/dfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-32 byte update for the frame deframer.
// No dependencies; the parser, the result queue and the top level import it.
package dfr_pkg;

    localparam int unsigned MIN_FRAME_BYTES = 1 + 4 + 1 + 2 + 4;
    localparam int unsigned HEADER_BYTES    = 8;
    localparam int unsigned MIC_BYTES       = 4;

    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [7:0]  FOPTS_MASK   = 8'h0F;
    localparam logic [7:0]  VERSION_MASK = 8'h03;

    typedef enum logic [1:0] {
        KIND_OPTION  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        status_t     status;
        logic [2:0]  message_type;
        logic [1:0]  major_version;
        logic [31:0] device_address;
        logic [7:0]  frame_control;
        logic [15:0] frame_counter;
        logic [7:0]  payload_length;
        logic        last_of_run;
    } result_t;

    // Results produced by one byte: an optional released byte, then an
    // optional frame summary.
    typedef struct packed {
        logic    byte_valid;
        logic    sum_valid;
        result_t byte_res;
        result_t sum_res;
    } push_t;

    // Reflected CRC-32, one byte, unrolled over its eight bit steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/dfr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame bytes and for parser results.
// Depends on nothing; widths follow the deframer's item fields.
interface dfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface dfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic [2:0]  message_type;
    logic [1:0]  major_version;
    logic [31:0] device_address;
    logic [7:0]  frame_control;
    logic [15:0] frame_counter;
    logic [7:0]  payload_length;
    logic        last_of_run;

    modport source (output valid, output kind, output byte_value, output status,
                    output message_type, output major_version, output device_address,
                    output frame_control, output frame_counter, output payload_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input byte_value, input status,
                    input message_type, input major_version, input device_address,
                    input frame_control, input frame_counter, input payload_length,
                    input last_of_run, output ready);
endinterface

>>> design/dfr_parser.sv
`timescale 1ns / 1ps
// Input register, delay line, CRC and header capture of the deframer.
// Depends on dfr_pkg and dfr_byte_if; hands its results to the output queue.
module dfr_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 255
) (
    input  logic           clk,
    input  logic           rst_n,
    dfr_byte_if.sink       frame_bytes,
    input  logic           queue_room,
    output dfr_pkg::push_t push
);
    import dfr_pkg::*;

    localparam int unsigned BS_W  = $clog2(MAX_FRAME_BYTES + 2);
    localparam int unsigned CMP_W = BS_W + 1;
    localparam logic [BS_W-1:0] MAX_BS  = BS_W'(MAX_FRAME_BYTES);
    localparam logic [BS_W-1:0] OVER_BS = BS_W'(MAX_FRAME_BYTES + 1);

    // Input register.
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_eof_reg;
    logic       take, advance;

    // Frame state.
    logic [7:0]      held_reg [MIC_BYTES];
    logic [7:0]      held_next [MIC_BYTES];
    logic [BS_W-1:0] seen_reg, seen_next;
    logic [31:0]     crc_reg, crc_next;
    logic [7:0]      header_reg, header_next;
    logic [31:0]     address_reg, address_next;
    logic [7:0]      control_reg, control_next;
    logic [15:0]     counter_reg, counter_next;

    logic [BS_W-1:0]  pos, pos_opt;
    logic [7:0]       rel;
    logic [3:0]       fopts;
    logic [CMP_W-1:0] body, hdr_opts;
    logic [31:0]      mic;
    status_t          status;
    logic [7:0]       plen;

    assign advance           = stage_valid_reg && queue_room;
    assign frame_bytes.ready = !stage_valid_reg || queue_room;
    assign take              = frame_bytes.valid && frame_bytes.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MIC_BYTES; i++)
        begin
            held_next[i] = held_reg[i];
        end
        seen_next    = seen_reg;
        crc_next     = crc_reg;
        header_next  = header_reg;
        address_next = address_reg;
        control_next = control_reg;
        counter_next = counter_reg;
        pos          = seen_reg - BS_W'(MIC_BYTES);
        pos_opt      = pos - BS_W'(HEADER_BYTES);
        rel          = held_reg[0];
        push         = '0;

        if (seen_reg < MAX_BS)
        begin
            if (seen_reg >= BS_W'(MIC_BYTES))
            begin
                // The oldest held byte cannot be part of the check any more.
                crc_next = crc32_byte(crc_reg, rel);
                if (pos == BS_W'(0))
                begin
                    header_next = rel;
                end
                else if (pos <= BS_W'(4))
                begin
                    address_next[8 * 2'(pos - BS_W'(1)) +: 8] = rel;
                end
                else if (pos == BS_W'(5))
                begin
                    control_next = rel;
                end
                else if (pos == BS_W'(6))
                begin
                    counter_next[7:0] = rel;
                end
                else if (pos == BS_W'(7))
                begin
                    counter_next[15:8] = rel;
                end
                else
                begin
                    push.byte_valid          = 1'b1;
                    push.byte_res.kind       = (pos_opt < BS_W'(control_reg[3:0])) ?
                                               KIND_OPTION : KIND_PAYLOAD;
                    push.byte_res.byte_value = rel;
                    push.byte_res.last_of_run = !stage_eof_reg;
                end
            end
            for (int i = 0; i < MIC_BYTES - 1; i++)
            begin
                held_next[i] = held_reg[i + 1];
            end
            held_next[MIC_BYTES - 1] = stage_byte_reg;
            seen_next = seen_reg + BS_W'(1);
        end
        else
        begin
            // Bytes past the frame bound are dropped.
            seen_next = OVER_BS;
        end

        // Frame summary, taken from the state after this byte.
        fopts    = control_next[3:0];
        body     = CMP_W'(seen_next) - CMP_W'(MIC_BYTES);
        hdr_opts = CMP_W'(HEADER_BYTES) + CMP_W'(fopts);
        mic      = {held_next[3], held_next[2], held_next[1], held_next[0]};
        plen     = 8'd0;
        if (seen_next > MAX_BS)
        begin
            status = ST_TOO_LONG;
        end
        else if (seen_next < BS_W'(MIN_FRAME_BYTES))
        begin
            status = ST_SHORT;
        end
        else if (mic != ~crc_next)
        begin
            status = ST_MISMATCH;
        end
        else if (hdr_opts > body)
        begin
            status = ST_OVERRUN;
        end
        else
        begin
            status = ST_OK;
            plen   = 8'(body - hdr_opts);
        end

        if (stage_eof_reg)
        begin
            push.sum_valid                  = 1'b1;
            push.sum_res.kind               = KIND_SUMMARY;
            push.sum_res.status             = status;
            push.sum_res.message_type       = header_next[7:5];
            push.sum_res.major_version      = 2'(header_next & VERSION_MASK);
            push.sum_res.device_address     = address_next;
            push.sum_res.frame_control      = control_next;
            push.sum_res.frame_counter      = counter_next;
            push.sum_res.payload_length     = plen;
            push.sum_res.last_of_run        = 1'b1;
            // A frame end returns every piece of frame state to reset.
            for (int i = 0; i < MIC_BYTES; i++)
            begin
                held_next[i] = 8'd0;
            end
            seen_next    = '0;
            crc_next     = CRC_INIT;
            header_next  = 8'd0;
            address_next = 32'd0;
            control_next = 8'd0;
            counter_next = 16'd0;
        end

        if (!advance)
        begin
            push = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            for (int i = 0; i < MIC_BYTES; i++)
            begin
                held_reg[i] <= 8'd0;
            end
            seen_reg    <= '0;
            crc_reg     <= CRC_INIT;
            header_reg  <= 8'd0;
            address_reg <= 32'd0;
            control_reg <= 8'd0;
            counter_reg <= 16'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (advance)
            begin
                for (int i = 0; i < MIC_BYTES; i++)
                begin
                    held_reg[i] <= held_next[i];
                end
                seen_reg    <= seen_next;
                crc_reg     <= crc_next;
                header_reg  <= header_next;
                address_reg <= address_next;
                control_reg <= control_next;
                counter_reg <= counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= frame_bytes.data_byte;
            stage_eof_reg  <= frame_bytes.end_of_frame;
        end
    end

`ifndef SYNTH
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= OVER_BS)
        else $error("byte count exceeded its saturation value");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.byte_valid && push.sum_valid |-> !push.byte_res.last_of_run)
        else $error("released byte marked last although a summary follows");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push.sum_valid |=> (seen_reg == '0) && (crc_reg == CRC_INIT))
        else $error("frame state not cleared after a summary");
`endif

endmodule

>>> design/dfr_result_fifo.sv
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results a cycle.
// Depends on dfr_pkg and dfr_result_if; drives the result channel.
module dfr_result_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  dfr_pkg::push_t push,
    output logic           queue_room,
    dfr_result_if.source   results
);
    import dfr_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] sum_ptr;
    result_t          head;

    assign queue_room = count_reg <= CNT_W'(DEPTH - 2);
    assign pop        = results.valid && results.ready;
    assign sum_ptr    = wr_ptr_reg + PTR_W'(push.byte_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.byte_valid) + PTR_W'(push.sum_valid);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.byte_valid) + CNT_W'(push.sum_valid)
                      - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.byte_valid)
        begin
            mem[wr_ptr_reg] <= push.byte_res;
        end
        if (push.sum_valid)
        begin
            mem[sum_ptr] <= push.sum_res;
        end
    end

    assign head                   = mem[rd_ptr_reg];
    assign results.valid          = count_reg != '0;
    assign results.kind           = head.kind;
    assign results.byte_value     = head.byte_value;
    assign results.status         = head.status;
    assign results.message_type   = head.message_type;
    assign results.major_version  = head.major_version;
    assign results.device_address = head.device_address;
    assign results.frame_control  = head.frame_control;
    assign results.frame_counter  = head.frame_counter;
    assign results.payload_length = head.payload_length;
    assign results.last_of_run    = head.last_of_run;

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflowed");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.byte_valid || push.sum_valid) |-> count_reg <= CNT_W'(DEPTH - 2))
        else $error("results pushed without room for a full pair");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> results.valid)
        else $error("result valid dropped before its transfer");
`endif

endmodule

>>> design/mac_frame_deframer_crc32.sv
`timescale 1ns / 1ps
// Top level of the MAC frame deframer with CRC-32 message check.
// Depends on dfr_pkg, dfr_if, dfr_parser and dfr_result_fifo.
//
//   Channel       Role   Carries
//   frame_bytes   sink   data_byte, end_of_frame: one decoded frame byte
//   results       source option/payload byte or frame summary, last_of_run
//
// A byte transfer is registered; once the queue has room, the delay line, the
// unrolled CRC-32 update and the header capture handle it in one pass and write
// up to two results into a four-entry queue. One byte per cycle is sustained
// while the result side keeps taking results. Reset is asynchronous and active
// low and clears all frame state. A result stall fills the queue; the input
// register then holds its byte and drops ready.
module mac_frame_deframer_crc32 #(
    parameter int unsigned MAX_FRAME_BYTES = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    dfr_byte_if.sink     frame_bytes,
    dfr_result_if.source results
);
    import dfr_pkg::*;

    // Results of the byte in process, handed from the parser to the queue.
    push_t push;
    // The queue can absorb a full pair of results this cycle.
    logic  queue_room;

    dfr_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_bytes (frame_bytes),
        .queue_room  (queue_room),
        .push        (push)
    );

    dfr_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .queue_room (queue_room),
        .results    (results)
    );

endmodule

>>> test/mac_frame_deframer_crc32_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MAC frame deframer with CRC-32 message check.
// Depends on dfr_pkg, dfr_if and mac_frame_deframer_crc32 from the design folder.
module mac_frame_deframer_crc32_tb;

    import dfr_pkg::*;

    // Frame length bound used for the instance and for the deframing predictor.
    localparam int unsigned MAX_LEN = 255;
    // Hard cycle limit.
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;

    dfr_byte_if   fb ();
    dfr_result_if res ();

    mac_frame_deframer_crc32 #(
        .MAX_FRAME_BYTES(MAX_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_bytes (fb),
        .results     (res)
    );

    // Pacing knobs, read by the byte sender and by the ready driver.
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    // Remaining cycles of a forced hold-off on the result side.
    int unsigned hold_left;

    int unsigned cycle_count;
    int unsigned errors;

    // Results that the deframer must still produce, oldest first.
    result_t expected_results[$];

    // Bytes of the frame that is about to be sent.
    logic [7:0] frame_buf[$];

    // Private copy of the deframer state: the four-byte delay line that holds
    // back a possible message check, the byte count of the current frame, the
    // running CRC and the captured header fields.
    logic [7:0]  delay_line[4];
    int unsigned frame_pos;
    logic [31:0] crc_acc;
    logic [7:0]  hdr_byte;
    logic [31:0] dev_addr;
    logic [7:0]  ctl_byte;
    logic [15:0] frame_cnt;

    // ------------------------------------------------------------------
    // Clock, cycle counter and timeout.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("mac_frame_deframer_crc32_tb: FAIL");
                $finish;
            end
        end
    end

    // The hold-off is counted down here, in cycles, independently of the
    // sender, so the sender keeps offering bytes while the result side is
    // blocked and the deframer has to stall its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result-side ready. It changes only at the falling edge.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res.ready = 1'b0;
            end
            else
            begin
                res.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Deframing predictor.
    // ------------------------------------------------------------------

    // Reflected CRC-32, fed one data bit at a time, least significant first.
    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
        logic fb_bit;
        for (int i = 0; i < 8; i++)
        begin
            fb_bit = c[0] ^ d[i];
            c = c >> 1;
            if (fb_bit)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        for (int i = 0; i < 4; i++)
        begin
            delay_line[i] = 8'h00;
        end
        frame_pos = 0;
        crc_acc   = CRC_INIT;
        hdr_byte  = 8'h00;
        dev_addr  = 32'h0;
        ctl_byte  = 8'h00;
        frame_cnt = 16'h0;
    endtask

    // Advances the predictor by one accepted byte and queues the results it
    // causes: at most one released option or payload byte, then at frame end
    // the summary.
    task automatic deframe_byte(input logic [7:0] b, input logic eof);
        result_t     r;
        status_t     st;
        int unsigned pos;
        int unsigned n_opts;
        int unsigned body;
        logic [7:0]  released;
        logic [31:0] mic;
        logic [7:0]  plen;

        if (frame_pos < MAX_LEN)
        begin
            // Once four bytes are held, the oldest one cannot be part of the
            // trailing check, so it goes through the CRC and the parser.
            if (frame_pos >= 4)
            begin
                pos = frame_pos - 4;
                released = delay_line[0];
                crc_acc = crc_update(crc_acc, released);
                if (pos == 0)
                begin
                    hdr_byte = released;
                end
                else if (pos <= 4)
                begin
                    dev_addr[8 * (pos - 1) +: 8] = released;
                end
                else if (pos == 5)
                begin
                    ctl_byte = released;
                end
                else if (pos == 6)
                begin
                    frame_cnt[7:0] = released;
                end
                else if (pos == 7)
                begin
                    frame_cnt[15:8] = released;
                end
                else
                begin
                    n_opts = 32'(ctl_byte & FOPTS_MASK);
                    r = '0;
                    r.kind = (pos - HEADER_BYTES < n_opts) ? KIND_OPTION : KIND_PAYLOAD;
                    r.byte_value = released;
                    r.last_of_run = !eof;
                    expected_results = {expected_results, r};
                end
            end
            delay_line[0] = delay_line[1];
            delay_line[1] = delay_line[2];
            delay_line[2] = delay_line[3];
            delay_line[3] = b;
            frame_pos++;
        end
        else
        begin
            // Bytes past the length bound are dropped; the count saturates.
            frame_pos = MAX_LEN + 1;
        end

        if (eof)
        begin
            n_opts = 32'(ctl_byte & FOPTS_MASK);
            plen = 8'h00;
            if (frame_pos > MAX_LEN)
            begin
                st = ST_TOO_LONG;
            end
            else if (frame_pos < MIN_FRAME_BYTES)
            begin
                st = ST_SHORT;
            end
            else
            begin
                mic = {delay_line[3], delay_line[2], delay_line[1], delay_line[0]};
                body = frame_pos - MIC_BYTES;
                if (mic != ~crc_acc)
                begin
                    st = ST_MISMATCH;
                end
                else if (HEADER_BYTES + n_opts > body)
                begin
                    st = ST_OVERRUN;
                end
                else
                begin
                    st = ST_OK;
                    plen = 8'(body - HEADER_BYTES - n_opts);
                end
            end
            r = '0;
            r.kind = KIND_SUMMARY;
            r.status = st;
            r.message_type = hdr_byte[7:5];
            r.major_version = 2'(hdr_byte & VERSION_MASK);
            r.device_address = dev_addr;
            r.frame_control = ctl_byte;
            r.frame_counter = frame_cnt;
            r.payload_length = plen;
            r.last_of_run = 1'b1;
            expected_results = {expected_results, r};
            clear_frame_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expected result (kind %0d)", res.kind);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, res.kind);
                check_field("byte_value", want.byte_value, res.byte_value);
                check_field("status", want.status, res.status);
                check_field("message_type", want.message_type, res.message_type);
                check_field("major_version", want.major_version, res.major_version);
                check_field("device_address", want.device_address, res.device_address);
                check_field("frame_control", want.frame_control, res.frame_control);
                check_field("frame_counter", want.frame_counter, res.frame_counter);
                check_field("payload_length", want.payload_length, res.payload_length);
                check_field("last_of_run", want.last_of_run, res.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender and frame construction.
    // ------------------------------------------------------------------

    // Offers one byte and returns at the falling edge after its transfer.
    // It is always entered at a falling edge, so each input changes at most
    // once per time step.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            fb.valid = 1'b0;
            @(negedge clk);
        end
        fb.valid = 1'b1;
        fb.data_byte = b;
        fb.end_of_frame = eof;
        @(posedge clk);
        while (!fb.ready)
        begin
            @(posedge clk);
        end
        deframe_byte(b, eof);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
        begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Assembles a frame: header, n_extra option/payload bytes of random
    // content, then the little-endian message check, optionally with one bit
    // flipped.
    task automatic compose_frame(input logic [7:0] mhdr, input logic [31:0] addr,
                                 input logic [7:0] fctrl, input logic [15:0] fcnt,
                                 input int unsigned n_extra, input bit bad_mic);
        logic [31:0] c;
        frame_buf.delete();
        frame_buf = {frame_buf, mhdr};
        for (int i = 0; i < 4; i++)
        begin
            frame_buf = {frame_buf, addr[8 * i +: 8]};
        end
        frame_buf = {frame_buf, fctrl};
        frame_buf = {frame_buf, fcnt[7:0]};
        frame_buf = {frame_buf, fcnt[15:8]};
        for (int unsigned i = 0; i < n_extra; i++)
        begin
            frame_buf = {frame_buf, 8'($urandom_range(255))};
        end
        c = CRC_INIT;
        foreach (frame_buf[i])
        begin
            c = crc_update(c, frame_buf[i]);
        end
        c = ~c;
        if (bad_mic)
        begin
            c = c ^ (32'd1 << $urandom_range(31));
        end
        for (int i = 0; i < 4; i++)
        begin
            frame_buf = {frame_buf, c[8 * i +: 8]};
        end
    endtask

    task automatic fill_random(input int unsigned len);
        frame_buf.delete();
        for (int unsigned i = 0; i < len; i++)
        begin
            frame_buf = {frame_buf, 8'($urandom_range(255))};
        end
    endtask

    // Lowers valid and waits until every expected result has arrived, then waits
    // on so that anything unexpected that follows is caught.
    task automatic wait_for_results();
        fb.valid = 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A one-byte frame, an all-ones header with one option byte and no
    // payload, and an all-zero header whose option length overruns the frame.
    task automatic test_directed_frames();
        send_idle_pct = 0;
        stall_pct = 0;
        frame_buf.delete();
        frame_buf = {frame_buf, 8'hFF};
        send_frame();
        compose_frame(8'hFF, 32'hFFFF_FFFF, 8'hF1, 16'hFFFF, 1, 1'b0);
        send_frame();
        compose_frame(8'h00, 32'h0000_0000, 8'h0F, 16'h0000, 0, 1'b0);
        send_frame();
        wait_for_results();
    endtask

    // Frame lengths around both bounds: the longest accepted frame with the
    // largest payload, one byte more, one byte below the minimum, and the
    // minimum length with a corrupted check.
    task automatic test_length_boundaries();
        send_idle_pct = 0;
        stall_pct = 0;
        compose_frame(8'($urandom_range(255)), $urandom, 8'hF0,
                      16'($urandom_range(65535)), MAX_LEN - MIN_FRAME_BYTES, 1'b0);
        send_frame();
        compose_frame(8'($urandom_range(255)), $urandom, 8'($urandom_range(255)),
                      16'($urandom_range(65535)), MAX_LEN - MIN_FRAME_BYTES + 1, 1'b0);
        send_frame();
        compose_frame(8'($urandom_range(255)), $urandom, 8'h00,
                      16'($urandom_range(65535)), 0, 1'b0);
        void'(frame_buf.pop_back());
        send_frame();
        compose_frame(8'($urandom_range(255)), $urandom, 8'h00,
                      16'($urandom_range(65535)), 0, 1'b1);
        send_frame();
        wait_for_results();
    endtask

    // The result side holds off for a long stretch while bytes keep coming,
    // so the result queue fills and the deframer drops ready on its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 400;
        for (int i = 0; i < 3; i++)
        begin
            compose_frame(8'($urandom_range(255)), $urandom, 8'h02,
                          16'($urandom_range(65535)), 20, 1'b0);
            send_frame();
        end
        wait_for_results();
    endtask

    // Random frames, mostly well formed with random content; the rest carry a
    // bad check, an overrunning option length, too few bytes, plain noise or
    // too many bytes.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall,
                                       input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned n_extra;
        logic [7:0]  fctrl;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            fctrl = 8'($urandom_range(255));
            if (pick < 80)
            begin
                n_extra = $urandom_range(24);
                if (fctrl[3:0] > n_extra)
                begin
                    fctrl[3:0] = 4'(n_extra);
                end
                compose_frame(8'($urandom_range(255)), $urandom, fctrl,
                              16'($urandom_range(65535)), n_extra, pick >= 70);
            end
            else if (pick < 87)
            begin
                n_extra = $urandom_range(14);
                fctrl[3:0] = 4'($urandom_range(15, n_extra + 1));
                compose_frame(8'($urandom_range(255)), $urandom, fctrl,
                              16'($urandom_range(65535)), n_extra, 1'b0);
            end
            else if (pick < 95)
            begin
                fill_random($urandom_range(1, MIN_FRAME_BYTES - 1));
            end
            else if (pick < 99)
            begin
                fill_random($urandom_range(1, 40));
            end
            else
            begin
                compose_frame(8'($urandom_range(255)), $urandom, fctrl,
                              16'($urandom_range(65535)),
                              $urandom_range(MAX_LEN - MIN_FRAME_BYTES + 1,
                                             MAX_LEN - MIN_FRAME_BYTES + 8), 1'b0);
            end
            // Dropped bytes of an overlong frame do not count as traffic.
            sent += (frame_buf.size() < MAX_LEN) ? frame_buf.size() : MAX_LEN;
            send_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial
    begin
        fb.valid = 1'b0;
        fb.data_byte = 8'h00;
        fb.end_of_frame = 1'b0;
        rst_n = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        errors = 0;
        clear_frame_state();

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_length_boundaries();
        test_backpressure();
        // Pacing phases: free running, a mostly idle sender, a mostly
        // stalling receiver, then both idling part of the time.
        test_random_traffic(0, 0, 350);
        test_random_traffic(75, 0, 350);
        test_random_traffic(0, 75, 350);
        test_random_traffic(30, 30, 350);
        wait_for_results();

        if (errors == 0)
        begin
            $display("mac_frame_deframer_crc32_tb: PASS");
        end
        else
        begin
            $display("mac_frame_deframer_crc32_tb: FAIL");
        end
        $finish;
    end

endmodule
